// ===== rtl/ipv6tc_pkg.sv =====
// Package for the IPv6 address text compressor.
// Shared types for the front classifier, the command queue and the text emitter.
package ipv6tc_pkg;

  typedef enum logic [1:0] {
    MODE_GENERAL = 2'd0,
    MODE_COMPAT  = 2'd1,
    MODE_MAPPED  = 2'd2
  } mode_e;

  // Classified address work, produced by the front part.
  typedef struct packed {
    logic [127:0] addr;
    mode_e        mode;
    logic         has_run;
    logic [2:0]   run_start;
    logic [3:0]   run_end;
    logic         prefix_used;
    logic [7:0]   prefix_length;
  } cmd_t;

  typedef enum logic [2:0] {
    PH_HEAD   = 3'd0,
    PH_DCOL   = 3'd1,
    PH_HEX    = 3'd2,
    PH_SEP    = 3'd3,
    PH_DOT    = 3'd4,
    PH_PERIOD = 3'd5,
    PH_SLASH  = 3'd6,
    PH_PFX    = 3'd7
  } phase_e;

  localparam logic [6:0] ChColon  = 7'h3a;
  localparam logic [6:0] ChPeriod = 7'h2e;
  localparam logic [6:0] ChSlash  = 7'h2f;
  localparam logic [6:0] ChZero   = 7'h30;

  function automatic logic [6:0] hex_char(input logic [3:0] d);
    hex_char = (d < 4'd10) ? (7'h30 + {3'd0, d}) : (7'h57 + {3'd0, d});
  endfunction

endpackage

// ===== rtl/ipv6tc_front.sv =====
// Front part: accepts addresses and finds the longest zero-word run.
// Depends on ipv6tc_pkg.
module ipv6tc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [127:0]      addr_i,
  input  logic              compat_i,
  input  logic              mapped_i,
  input  logic              pfx_used_i,
  input  logic [7:0]        pfx_len_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output ipv6tc_pkg::cmd_t  cmd_o
);
  logic             valid_q;
  ipv6tc_pkg::cmd_t cmd_q, cmd_d;
  logic [7:0]       zero;
  logic [3:0]       best_len, cur_len;
  logic [2:0]       best_st, cur_st;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      zero[i] = (addr_i[127 - 16*i -: 16] == 16'd0);
    end
    best_len = 4'd0;
    best_st  = 3'd0;
    cur_len  = 4'd0;
    cur_st   = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (zero[i]) begin
        if (cur_len == 4'd0) cur_st = 3'(i);
        cur_len = cur_len + 4'd1;
        if (cur_len > best_len) begin
          best_len = cur_len;
          best_st  = cur_st;
        end
      end else begin
        cur_len = 4'd0;
      end
    end
    cmd_d.addr          = addr_i;
    cmd_d.mode          = compat_i ? ipv6tc_pkg::MODE_COMPAT :
                          mapped_i ? ipv6tc_pkg::MODE_MAPPED : ipv6tc_pkg::MODE_GENERAL;
    cmd_d.has_run       = (best_len >= 4'd2);
    cmd_d.run_start     = best_st;
    cmd_d.run_end       = {1'b0, best_st} + best_len;
    cmd_d.prefix_used   = pfx_used_i;
    cmd_d.prefix_length = pfx_len_i;
  end

  assign in_ready_o  = !valid_q || cmd_ready_i;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) cmd_q <= cmd_d;
  end
endmodule

// ===== rtl/ipv6tc_queue.sv =====
// Two-entry queue between front and back parts.
// Depends on ipv6tc_pkg.
module ipv6tc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  ipv6tc_pkg::cmd_t  wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output ipv6tc_pkg::cmd_t  rd_data_o
);
  ipv6tc_pkg::cmd_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule

// ===== rtl/ipv6tc_back.sv =====
// Back part: walks a classified address and emits one character per cycle while the output accepts it.
// Depends on ipv6tc_pkg.
module ipv6tc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  ipv6tc_pkg::cmd_t  cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [6:0]        out_char_o,
  output logic              out_last_o
);
  ipv6tc_pkg::phase_e ph_q, ph_d;
  logic [2:0]       wi_q, wi_d;   // word index
  logic [1:0]       di_q, di_d;   // first digit position still to emit
  logic [1:0]       bi_q, bi_d;   // byte index of the dotted tail
  logic             ov_q;
  logic [6:0]       ch_q;
  logic             last_q;

  logic [15:0] word;
  logic [1:0]  hex_lead, hex_pos;
  logic [3:0]  hdig;
  logic [7:0]  dec_v, dec_rem;
  logic [15:0] tens_prod;
  logic [3:0]  hund, tens, ones, ddig;
  logic [1:0]  dec_lead, dec_pos;
  logic        head_colon, hex_now, step, end_txt;
  logic [6:0]  ch;
  logic        last;

  assign out_valid_o = ov_q;
  assign out_char_o  = ch_q;
  assign out_last_o  = last_q;
  assign step        = cmd_valid_i && (!ov_q || out_ready_i);
  assign cmd_ready_o = step && last;

  // Item start opens with "::" for the dotted forms and for a leading zero run.
  assign head_colon = (cmd_i.mode != ipv6tc_pkg::MODE_GENERAL) ||
                      (cmd_i.has_run && cmd_i.run_start == 3'd0);
  assign hex_now    = (ph_q == ipv6tc_pkg::PH_HEX) ||
                      (ph_q == ipv6tc_pkg::PH_HEAD && !head_colon);

  always_comb begin
    word = cmd_i.addr[127 - 16*wi_q -: 16];
    if (word[15:12] != 4'd0)     hex_lead = 2'd0;
    else if (word[11:8] != 4'd0) hex_lead = 2'd1;
    else if (word[7:4] != 4'd0)  hex_lead = 2'd2;
    else                         hex_lead = 2'd3;
    // skip leading zero digits
    hex_pos = (di_q > hex_lead) ? di_q : hex_lead;
    case (hex_pos)
      2'd0:    hdig = word[15:12];
      2'd1:    hdig = word[11:8];
      2'd2:    hdig = word[7:4];
      default: hdig = word[3:0];
    endcase

    if (ph_q == ipv6tc_pkg::PH_PFX) dec_v = cmd_i.prefix_length;
    else                            dec_v = cmd_i.addr[31 - 8*bi_q -: 8];
    if (dec_v >= 8'd200) begin
      hund = 4'd2; dec_rem = dec_v - 8'd200;
    end else if (dec_v >= 8'd100) begin
      hund = 4'd1; dec_rem = dec_v - 8'd100;
    end else begin
      hund = 4'd0; dec_rem = dec_v;
    end
    // x * 205 >> 11 gives x / 10 for every x below 100
    tens_prod = {8'd0, dec_rem} * 16'd205;
    tens      = 4'(tens_prod >> 11);
    ones      = 4'(dec_rem - {1'b0, tens, 3'd0} - {3'd0, tens, 1'b0});
    dec_lead  = (dec_v >= 8'd100) ? 2'd0 : (dec_v >= 8'd10) ? 2'd1 : 2'd2;
    dec_pos   = (di_q > dec_lead) ? di_q : dec_lead;
    case (dec_pos)
      2'd0:    ddig = hund;
      2'd1:    ddig = tens;
      default: ddig = ones;
    endcase
  end

  always_comb begin
    ph_d = ph_q; wi_d = wi_q; di_d = di_q; bi_d = bi_q;
    ch = ipv6tc_pkg::ChColon; last = 1'b0; end_txt = 1'b0;
    if (hex_now) begin
      ch = ipv6tc_pkg::hex_char(hdig);
      ph_d = ipv6tc_pkg::PH_HEX;
      di_d = hex_pos + 2'd1;
      if (hex_pos == 2'd3) begin
        di_d = 2'd0;
        if (cmd_i.mode == ipv6tc_pkg::MODE_MAPPED) begin
          ph_d = ipv6tc_pkg::PH_SEP;
        end else if (wi_q == 3'd7) begin
          end_txt = 1'b1;
        end else begin
          wi_d = wi_q + 3'd1; ph_d = ipv6tc_pkg::PH_SEP;
        end
      end
    end else begin
      unique case (ph_q)
        ipv6tc_pkg::PH_HEAD: begin
          ph_d = ipv6tc_pkg::PH_DCOL;
        end
        ipv6tc_pkg::PH_DCOL: begin
          di_d = 2'd0; bi_d = 2'd0;
          if (cmd_i.mode == ipv6tc_pkg::MODE_COMPAT) begin
            ph_d = ipv6tc_pkg::PH_DOT;
          end else if (cmd_i.mode == ipv6tc_pkg::MODE_MAPPED) begin
            ph_d = ipv6tc_pkg::PH_HEX; wi_d = 3'd5;
          end else if (cmd_i.run_end == 4'd8) begin
            end_txt = 1'b1;
          end else begin
            ph_d = ipv6tc_pkg::PH_HEX; wi_d = cmd_i.run_end[2:0];
          end
        end
        ipv6tc_pkg::PH_SEP: begin
          di_d = 2'd0;
          if (cmd_i.mode == ipv6tc_pkg::MODE_MAPPED) begin
            ph_d = ipv6tc_pkg::PH_DOT; bi_d = 2'd0;
          end else if (cmd_i.has_run && wi_q == cmd_i.run_start) begin
            ph_d = ipv6tc_pkg::PH_DCOL;   // second colon of the zero run
          end else begin
            ph_d = ipv6tc_pkg::PH_HEX;
          end
        end
        ipv6tc_pkg::PH_DOT, ipv6tc_pkg::PH_PFX: begin
          ch = ipv6tc_pkg::ChZero + {3'd0, ddig};
          di_d = dec_pos + 2'd1;
          if (dec_pos == 2'd2) begin
            di_d = 2'd0;
            if (ph_q == ipv6tc_pkg::PH_PFX) begin
              last = 1'b1;
            end else if (bi_q == 2'd3) begin
              end_txt = 1'b1;
            end else begin
              bi_d = bi_q + 2'd1; ph_d = ipv6tc_pkg::PH_PERIOD;
            end
          end
        end
        ipv6tc_pkg::PH_PERIOD: begin
          ch = ipv6tc_pkg::ChPeriod; ph_d = ipv6tc_pkg::PH_DOT; di_d = 2'd0;
        end
        ipv6tc_pkg::PH_SLASH: begin
          ch = ipv6tc_pkg::ChSlash; ph_d = ipv6tc_pkg::PH_PFX; di_d = 2'd0;
        end
        default: ph_d = ipv6tc_pkg::PH_HEAD;
      endcase
    end
    if (end_txt) begin
      if (cmd_i.prefix_used) ph_d = ipv6tc_pkg::PH_SLASH;
      else                   last = 1'b1;
    end
    if (last) begin
      ph_d = ipv6tc_pkg::PH_HEAD; wi_d = 3'd0; di_d = 2'd0; bi_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= ipv6tc_pkg::PH_HEAD; ov_q <= 1'b0;
      wi_q <= 3'd0; di_q <= 2'd0; bi_q <= 2'd0;
    end else if (step) begin
      ph_q <= ph_d; wi_q <= wi_d; di_q <= di_d; bi_q <= bi_d;
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      ch_q <= ch; last_q <= last;
    end
  end
endmodule

// ===== rtl/ipv6_address_text_compressor.sv =====
// Top level of the IPv6 address text compressor.
// Depends on ipv6tc_pkg, ipv6tc_front, ipv6tc_queue and ipv6tc_back.
//
//  channel | dir | tdata (low bits first)           | tuser (low bits first)  | tlast
//  s_axis  | in  | addr_upper, addr_lower, pfx_len  | compat, mapped, pfx_use | -
//  m_axis  | out | text_char, zero pad              | -                       | is_last
//
// One character leaves per cycle while m_axis_tready is high; an address gives 2 to 43
// characters, with no gap between addresses while work is queued.
// The first character passes the front register, a queue entry and the output register before it is valid.
// The front register and a two-entry queue take new addresses while the
// emitter works; input stalls only when both are full. Reset clears all
// control state asynchronously.
module ipv6_address_text_compressor (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,  // address_upper, address_lower, prefix_length
  input  logic [2:0]   s_axis_tuser,  // is_compat_v4, is_mapped, prefix_used
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata,  // text_char, zero pad
  output logic         m_axis_tlast   // is_last
);
  logic             f_valid, f_ready, q_valid, q_ready;
  ipv6tc_pkg::cmd_t f_cmd, q_cmd;
  logic [6:0]       chr;

  ipv6tc_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid), .in_ready_o (s_axis_tready),
    .addr_i     ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
    .compat_i   (s_axis_tuser[0]), .mapped_i (s_axis_tuser[1]),
    .pfx_used_i (s_axis_tuser[2]), .pfx_len_i (s_axis_tdata[135:128]),
    .cmd_valid_o (f_valid), .cmd_ready_i (f_ready), .cmd_o (f_cmd)
  );

  ipv6tc_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i (f_valid), .wr_ready_o (f_ready), .wr_data_i (f_cmd),
    .rd_valid_o (q_valid), .rd_ready_i (q_ready), .rd_data_o (q_cmd)
  );

  ipv6tc_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i (q_valid), .cmd_ready_o (q_ready), .cmd_i (q_cmd),
    .out_valid_o (m_axis_tvalid), .out_ready_i (m_axis_tready),
    .out_char_o (chr), .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, chr};
endmodule

// ===== verif/ipv6_address_text_checker.sv =====
// Checker for the IPv6 address text compressor: watches both streams,
// builds the expected text for each accepted address and compares characters.
// Depends on nothing but the ports of ipv6_address_text_compressor.
`timescale 1ns / 100ps

module ipv6_address_text_checker (
  input  logic         clk_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,
  input  logic [2:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [7:0]   m_axis_tdata,
  input  logic         m_axis_tlast,
  output int           fail_count_o,
  output int           pending_chars_o
);

  localparam logic [6:0] ChColon  = 7'h3a;
  localparam logic [6:0] ChPeriod = 7'h2e;
  localparam logic [6:0] ChSlash  = 7'h2f;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } text_char_t;

  text_char_t expected_text[$];
  text_char_t line[$];

  assign pending_chars_o = expected_text.size();

  initial fail_count_o = 0;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count_o++;
  endtask

  function automatic logic [6:0] hex_digit(input logic [3:0] d);
    return (d < 4'd10) ? 7'h30 + {3'd0, d} : 7'h57 + {3'd0, d};
  endfunction

  function automatic logic [15:0] addr_word(input logic [127:0] a, input int i);
    return a[127 - 16 * i -: 16];
  endfunction

  task automatic add_char(input logic [6:0] c);
    line.push_back('{ch: c, last: 1'b0});
  endtask

  task automatic add_hex(input logic [15:0] v);
    bit started;
    started = 0;
    for (int sh = 12; sh >= 0; sh -= 4) begin
      if (v[sh +: 4] != 0 || started || sh == 0) begin
        add_char(hex_digit(v[sh +: 4]));
        started = 1;
      end
    end
  endtask

  task automatic add_dec(input int unsigned v);
    if (v >= 100) add_char(7'(32'h30 + (v / 100) % 10));
    if (v >= 10) add_char(7'(32'h30 + (v / 10) % 10));
    add_char(7'(32'h30 + v % 10));
  endtask

  task automatic add_dotted(input logic [127:0] a);
    for (int sh = 24; sh >= 0; sh -= 8) begin
      add_dec(32'(a[sh +: 8]));
      if (sh != 0) add_char(ChPeriod);
    end
  endtask

  task automatic predict_text(input logic [127:0] a, input logic [2:0] u,
                              input logic [7:0] plen);
    int best_start, best_len, run_start, run_end;
    bit is_zero;
    best_start = -1;
    best_len = 0;
    run_start = -1;
    line.delete();
    if (u[0]) begin
      add_char(ChColon); add_char(ChColon);
      add_dotted(a);
    end else if (u[1]) begin
      add_char(ChColon); add_char(ChColon);
      add_hex(addr_word(a, 5));
      add_char(ChColon);
      add_dotted(a);
    end else begin
      for (int i = 0; i <= 8; i++) begin
        is_zero = (i < 8) && (addr_word(a, i) == 0);
        if (is_zero) begin
          if (run_start < 0) run_start = i;
        end else if (run_start >= 0) begin
          if (i - run_start >= 2 && i - run_start > best_len) begin
            best_start = run_start;
            best_len = i - run_start;
          end
          run_start = -1;
        end
      end
      if (best_start < 0) begin
        for (int i = 0; i < 8; i++) begin
          if (i != 0) add_char(ChColon);
          add_hex(addr_word(a, i));
        end
      end else begin
        run_end = best_start + best_len;
        for (int i = 0; i < best_start; i++) begin
          if (i != 0) add_char(ChColon);
          add_hex(addr_word(a, i));
        end
        add_char(ChColon); add_char(ChColon);
        for (int i = run_end; i < 8; i++) begin
          if (i != run_end) add_char(ChColon);
          add_hex(addr_word(a, i));
        end
      end
    end
    if (u[2]) begin
      add_char(ChSlash);
      add_dec(32'(plen));
    end
    line[line.size() - 1].last = 1'b1;
    foreach (line[i]) expected_text.push_back(line[i]);
  endtask

  always @(posedge clk_i) begin
    text_char_t want;
    if (s_axis_tvalid && s_axis_tready)
      predict_text({s_axis_tdata[63:0], s_axis_tdata[127:64]}, s_axis_tuser,
                   s_axis_tdata[135:128]);
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_text.size() == 0) begin
        report_mismatch($sformatf("unexpected char %h", m_axis_tdata));
      end else begin
        want = expected_text.pop_front();
        if (m_axis_tdata !== {1'b0, want.ch})
          report_mismatch($sformatf("char %h, want %h", m_axis_tdata, want.ch));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("tlast %b, want %b", m_axis_tlast, want.last));
      end
    end
  end

endmodule

// ===== verif/ipv6_address_text_compressor_test.sv =====
// Testbench top for the IPv6 address text compressor: drives addresses,
// stalls the text stream at random and gives the verdict.
// Depends on ipv6_address_text_compressor and ipv6_address_text_checker.
`timescale 1ns / 100ps

module ipv6_address_text_compressor_test;

  localparam int NumRandom = 470;
  localparam int CycleLimit = 2000000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [7:0]   m_axis_tdata;
  logic         m_axis_tlast;
  int           fail_count;
  int           pending_chars;
  int           cycle_count;
  bit           hold_off;

  ipv6_address_text_compressor uut (.*);

  ipv6_address_text_checker checker_i (
    .clk_i, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .fail_count_o(fail_count), .pending_chars_o(pending_chars)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Long receiver hold-off early in the random part, then random stalls.
  initial begin
    int gap;
    bit held;
    m_axis_tready = 0;
    held = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_off && !held) begin
        m_axis_tready <= 0;
        repeat (400) @(posedge clk_i);
        held = 1;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        m_axis_tready <= 0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_address(input logic [127:0] a, input bit compat, input bit mapped,
                              input bit pfx_used, input logic [7:0] pfx_len,
                              input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {pfx_len, a[63:0], a[127:64]};
    s_axis_tuser <= {pfx_used, mapped, compat};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic [127:0] random_address();
    logic [127:0] a;
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(0, 3))
        0, 1: a[16 * i +: 16] = 16'h0;
        2: a[16 * i +: 16] = 16'($urandom_range(0, 15) << (4 * $urandom_range(0, 3)));
        default: a[16 * i +: 16] = 16'($urandom);
      endcase
    end
    return a;
  endfunction

  initial begin
    logic [127:0] a;
    int gap;
    hold_off = 0;
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send_address('0, 1'b0, 1'b0, 1'b0, 8'd0, 0);
    send_address(128'h1, 1'b0, 1'b0, 1'b0, 8'd0, 0);
    send_address({128{1'b1}}, 1'b0, 1'b0, 1'b1, 8'd255, 0);
    send_address({128{1'b1}}, 1'b1, 1'b1, 1'b1, 8'd128, 0);
    send_address(128'h0000_0000_0000_0000_0000_0000_c0a8_0101, 1'b1, 1'b0, 1'b1, 8'd96, 0);
    send_address(128'h0000_0000_0000_0000_0000_ffff_0a00_0009, 1'b0, 1'b1, 1'b0, 8'd0, 0);
    send_address(128'h2001_0db8_0000_0000_0001_0000_0000_0001, 1'b0, 1'b0, 1'b1, 8'd0, 0);
    send_address(128'h0000_0000_0001_0000_0000_0001_0000_0000, 1'b0, 1'b0, 1'b1, 8'd9, 0);
    send_address(128'h0001_0000_0001_0000_0001_0000_0001_0000, 1'b0, 1'b0, 1'b0, 8'd0, 0);
    send_address(128'h1234_5678_9abc_def0_0fed_cba9_8765_4321, 1'b0, 1'b0, 1'b1, 8'd64, 0);
    send_address(128'h0000_0000_0000_0000_0000_0000_0000_0000, 1'b0, 1'b1, 1'b1, 8'd10, 0);
    send_address(128'hffff_0000_0000_0000_0000_0000_0000_0000, 1'b0, 1'b0, 1'b0, 8'd0, 0);
    send_address(128'h0000_0000_0000_0000_0000_0000_0000_ffff, 1'b0, 1'b0, 1'b1, 8'd1, 0);

    hold_off = 1;
    for (int n = 0; n < NumRandom; n++) begin
      a = random_address();
      case ($urandom_range(0, 9))
        0: a[127:32] = '0;
        1: a[127:32] = {80'h0, 16'hffff};
        2: a = {$urandom, $urandom, $urandom, $urandom};
        default: ;
      endcase
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
      send_address(a, $urandom_range(0, 7) == 0, $urandom_range(0, 5) == 0,
                   $urandom_range(0, 1) == 1, 8'($urandom_range(0, 255)), gap);
    end
    s_axis_tvalid <= 0;

    while (pending_chars != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending_chars == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
